/* hw/rtl/nfsa_pkg.sv */
// Package for the next-fit slot allocator: pool sizes, codes and shared types.
// Has no dependencies; every other file of the block refers to it by scoped names.
package nfsa_pkg;

    // Built pool capacity and the widths that follow from it.
    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    // Find-first-set unit: the map is split into groups that are searched side by side.
    localparam int FFS_GRP   = 8;
    localparam int FFS_NGRP  = NUM_SLOTS / FFS_GRP;
    localparam int FFS_GW    = $clog2(FFS_GRP);
    localparam int FFS_NW    = $clog2(FFS_NGRP);

    // Request codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_SCAN_HI = 2'd1,
        S_SCAN_LO = 2'd2,
        S_FREE    = 2'd3
    } state_t;

    // Configuration view handed from the register port to the sequencer.
    typedef struct packed {
        logic             reinit;
        logic [CNT_W-1:0] active;
    } cfg_t;

endpackage

/* hw/rtl/nfsa_chan_if.sv */
// Item channels of the next-fit slot allocator: request and response interfaces.
// Depends on nfsa_pkg for field widths.
interface nfsa_req_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [nfsa_pkg::SLOT_W-1:0]    slot_index;

    modport source (output valid, output func, output slot_index, input ready);
    modport sink   (input valid, input func, input slot_index, output ready);
endinterface

interface nfsa_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [nfsa_pkg::SLOT_W-1:0]    granted_slot;
    logic [nfsa_pkg::CNT_W-1:0]     free_count;

    modport source (output valid, output status, output granted_slot, output free_count,
                    input ready);
    modport sink   (input valid, input status, input granted_slot, input free_count,
                    output ready);
endinterface

/* hw/rtl/nfsa_ffs.sv */
// Shared find-first-set unit: lowest set bit of the masked free map.
// Depends on nfsa_pkg for the map width and the grouping of the search.
module nfsa_ffs
(
    input  logic [nfsa_pkg::NUM_SLOTS-1:0] vec,
    output logic                           hit,
    output logic [nfsa_pkg::SLOT_W-1:0]    pos
);

    logic [nfsa_pkg::FFS_NGRP-1:0]   grp_any;
    logic [nfsa_pkg::FFS_GW-1:0]     grp_pos [nfsa_pkg::FFS_NGRP];
    logic [nfsa_pkg::FFS_NW-1:0]     grp_sel;

    // Lowest set bit inside each group, all groups side by side.
    always_comb
    begin
        for (int g = 0; g < nfsa_pkg::FFS_NGRP; g++)
        begin
            grp_any[g] = |vec[g*nfsa_pkg::FFS_GRP +: nfsa_pkg::FFS_GRP];
            grp_pos[g] = '0;
            for (int j = nfsa_pkg::FFS_GRP - 1; j >= 0; j--)
            begin
                if (vec[g*nfsa_pkg::FFS_GRP + j])
                begin
                    grp_pos[g] = nfsa_pkg::FFS_GW'(j);
                end
            end
        end
    end

    // Lowest group that holds a set bit.
    always_comb
    begin
        grp_sel = '0;
        for (int g = nfsa_pkg::FFS_NGRP - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                grp_sel = nfsa_pkg::FFS_NW'(g);
            end
        end
    end

    assign hit = |grp_any;
    assign pos = {grp_sel, grp_pos[grp_sel]};

endmodule

/* hw/rtl/nfsa_ctrl.sv */
// Sequencer of the slot allocator: free map, search head, free count and result register.
// Depends on nfsa_pkg, the channel interfaces and the shared find-first-set unit nfsa_ffs.
module nfsa_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  nfsa_pkg::cfg_t  cfg,
    nfsa_req_if.sink        req,
    nfsa_rsp_if.source      rsp
);

    nfsa_pkg::state_t                   state_reg, state_next;
    logic [nfsa_pkg::NUM_SLOTS-1:0]     map_reg, map_next;
    logic [nfsa_pkg::SLOT_W-1:0]        head_reg, head_next;
    logic [nfsa_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [nfsa_pkg::SLOT_W-1:0]        idx_reg;

    logic                               rsp_valid_reg;
    nfsa_pkg::status_t                  status_reg, status_next;
    logic [nfsa_pkg::SLOT_W-1:0]        granted_reg, granted_next;
    logic [nfsa_pkg::CNT_W-1:0]         fcount_reg;

    logic [nfsa_pkg::NUM_SLOTS-1:0]     hi_mask, lo_mask, scan_vec;
    logic                               hit;
    logic [nfsa_pkg::SLOT_W-1:0]        hit_pos;
    logic                               out_free;
    logic                               commit;
    logic [nfsa_pkg::CNT_W-1:0]         grant_inc;

    // Search windows: from the head up to the end of the pool, then below the head.
    always_comb
    begin
        for (int i = 0; i < nfsa_pkg::NUM_SLOTS; i++)
        begin
            hi_mask[i] = (nfsa_pkg::CNT_W'(i) < cfg.active) &&
                         (nfsa_pkg::CNT_W'(i) >= {1'b0, head_reg});
            lo_mask[i] = nfsa_pkg::CNT_W'(i) < {1'b0, head_reg};
        end
        scan_vec = (state_reg == nfsa_pkg::S_SCAN_LO) ? (map_reg & lo_mask)
                                                      : (map_reg & hi_mask);
    end

    nfsa_ffs u_ffs
    (
        .vec (scan_vec),
        .hit (hit),
        .pos (hit_pos)
    );

    // The result register can take a new item when empty or being emptied.
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign grant_inc = {1'b0, hit_pos} + nfsa_pkg::CNT_W'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nfsa_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.func == nfsa_pkg::FUNC_FREE) ? nfsa_pkg::S_FREE
                                                                   : nfsa_pkg::S_SCAN_HI;
                end
            end
            nfsa_pkg::S_SCAN_HI:
            begin
                if (!hit)
                begin
                    state_next = nfsa_pkg::S_SCAN_LO;
                end
                else if (out_free)
                begin
                    state_next = nfsa_pkg::S_IDLE;
                end
            end
            nfsa_pkg::S_SCAN_LO,
            nfsa_pkg::S_FREE:
            begin
                if (out_free)
                begin
                    state_next = nfsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nfsa_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: the result of the step and its state update.
    always_comb
    begin
        commit       = 1'b0;
        status_next  = nfsa_pkg::STATUS_OK;
        granted_next = '0;
        map_next     = map_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        case (state_reg)
            nfsa_pkg::S_SCAN_HI,
            nfsa_pkg::S_SCAN_LO:
            begin
                commit = out_free && (hit || (state_reg == nfsa_pkg::S_SCAN_LO));
                if (hit)
                begin
                    granted_next     = hit_pos;
                    map_next[hit_pos] = 1'b0;
                    head_next        = (grant_inc == cfg.active) ? '0 : hit_pos + 1'b1;
                    count_next       = count_reg - 1'b1;
                end
                else
                begin
                    status_next = nfsa_pkg::STATUS_FULL;
                end
            end
            nfsa_pkg::S_FREE:
            begin
                commit = out_free;
                if ({1'b0, idx_reg} >= cfg.active)
                begin
                    status_next = nfsa_pkg::STATUS_RANGE;
                end
                else
                begin
                    map_next[idx_reg] = 1'b1;
                    count_next        = count_reg + nfsa_pkg::CNT_W'(!map_reg[idx_reg]);
                end
            end
            default:
            begin
                commit = 1'b0;
            end
        endcase
    end

    assign req.ready = (state_reg == nfsa_pkg::S_IDLE);

    // Sequencer state and pool state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfsa_pkg::S_IDLE;
            map_reg   <= '1;
            head_reg  <= '0;
            count_reg <= nfsa_pkg::CNT_W'(nfsa_pkg::NUM_SLOTS);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.reinit)
            begin
                map_reg   <= '1;
                head_reg  <= '0;
                count_reg <= cfg.active;
            end
            else if (commit)
            begin
                map_reg   <= map_next;
                head_reg  <= head_next;
                count_reg <= count_next;
            end
        end
    end

    // Slot index of a free request, held while it is worked on.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            idx_reg <= req.slot_index;
        end
    end

    // Result register between the sequencer and the response channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            fcount_reg  <= count_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.granted_slot = granted_reg;
    assign rsp.free_count   = fcount_reg;

`ifndef SYNTHESIS
    // A finished step always shows up as a pending result in the next cycle.
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp_valid_reg)
        else $error("nfsa_ctrl: committed result not presented");

    // A granted slot is marked taken after the step.
    a_grant_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && hit && (state_reg != nfsa_pkg::S_FREE) && !cfg.reinit)
        |=> !map_reg[$past(hit_pos)])
        else $error("nfsa_ctrl: granted slot still marked free");

    // An accepted request always leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != nfsa_pkg::S_IDLE))
        else $error("nfsa_ctrl: request accepted but sequencer idle");
`endif

endmodule

/* hw/rtl/next_fit_slot_allocator_unit.sv */
// Top level of the next-fit slot allocator: register port and channel wiring.
// Depends on nfsa_pkg, the channel interfaces and the sequencer nfsa_ctrl.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------------------
//  req      | in  | valid / ready  | func, slot_index
//  rsp      | out | valid / ready  | status, granted_slot, free_count
//  apb      | in  | psel / penable | paddr, pwdata, prdata (slots_in_use at 0)
//
// An allocate makes one find-first-set pass from the head to the end of the pool,
// and a second pass below the head when the first finds nothing; a free needs no
// search pass. The result register is loaded at the end of the last pass and
// offered from the next cycle. The request side is ready only while the sequencer
// is idle; a full result register stalls the sequencer in place. Reset and every
// write of slots_in_use mark all slots free and return the head to slot zero at once.
module next_fit_slot_allocator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    nfsa_req_if.sink    req,
    nfsa_rsp_if.source  rsp
);

    localparam logic [nfsa_pkg::CNT_W-1:0] CAP = nfsa_pkg::CNT_W'(nfsa_pkg::NUM_SLOTS);

    logic [6:0]                 slots_reg;
    logic                       cfg_wr;
    logic [6:0]                 slots_view;
    logic [nfsa_pkg::CNT_W-1:0] active;
    nfsa_pkg::cfg_t             cfg;

    // The single register decodes at every address of the port.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = {25'd0, slots_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= 7'd64;
        end
        else if (cfg_wr)
        begin
            slots_reg <= pwdata[6:0];
        end
    end

    // Effective pool size, saturated at the built capacity; a write shows its new value.
    assign slots_view = cfg_wr ? pwdata[6:0] : slots_reg;
    assign active     = (slots_view > CAP) ? CAP : slots_view;

    assign cfg.reinit = cfg_wr;
    assign cfg.active = active;

    nfsa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
